FILE: sv/vsfe_pkg.sv
// Shared types, frame constants and lookup tables for the vehicle status frame encoder.
// Used by the design files, the checker and the testbench; no dependencies.
package vsfe_pkg;

    localparam logic [1:0] FUNC_WHEEL = 2'd0;
    localparam logic [1:0] FUNC_DOOR  = 2'd1;
    localparam logic [1:0] FUNC_RADAR = 2'd2;

    localparam logic [1:0] RADAR_ON = 2'd2;

    localparam logic [7:0] SYNC0      = 8'h5a;
    localparam logic [7:0] SYNC1      = 8'ha5;
    localparam logic [7:0] TYPE_WHEEL = 8'h11;
    localparam logic [7:0] TYPE_DOOR  = 8'h12;
    localparam logic [7:0] TYPE_RADAR = 8'h41;

    localparam logic [7:0] PARK_FLAG0 = 8'h20;
    localparam logic [7:0] PARK_FLAG4 = 8'h03;

    localparam logic [4:0] LEN_WHEEL = 5'd10;
    localparam logic [4:0] LEN_DOOR  = 5'd7;
    localparam logic [4:0] LEN_RADAR = 5'd12;

    // sync, sync, length, type and checksum around the payload
    localparam int FRAME_OVERHEAD = 5;
    localparam int PAY_MAX        = 12;
    localparam int FRAME_MAX      = PAY_MAX + FRAME_OVERHEAD;
    localparam int CNT_W          = $clog2(FRAME_MAX + 1);

    localparam int DIST_MAX    = 99;
    localparam int LANES       = 8;
    localparam int LANE_W      = 7;
    localparam int PMAX_REV    = 165;
    localparam int PSTART_REV  = 1;
    localparam int PMAX_FWD    = 250;
    localparam int PSTART_FWD  = 5;
    localparam int ANGLE_NUM   = 27;
    localparam int ANGLE_DEN   = 5;

    typedef logic [(1 << LANE_W)-1:0][7:0] radar_lut_t;
    typedef logic [255:0][15:0]            angle_lut_t;

    typedef struct packed {
        logic [55:0]        radar_distances;
        logic [5:0]         door_open_mask;
        logic               reverse_selected;
        logic [1:0]         radar_state;
        logic signed [7:0]  wheel_percent;
        logic               wheel_valid;
        logic [1:0]         func;
    } item_t;

    typedef struct packed {
        logic                          emit;
        logic                          park_upd;
        logic                          park_val;
        logic [CNT_W-1:0]              len;
        logic [FRAME_MAX-1:0][7:0]     bytes;
    } frame_t;

    // byte sent for each raw lane code; codes above the range saturate
    function automatic radar_lut_t build_radar_lut(int pmax, int pstart);
        radar_lut_t lut;
        int         d;
        int         c;
        for (int i = 0; i < (1 << LANE_W); i++) begin
            d = (i > DIST_MAX) ? DIST_MAX : i;
            c = (d * pmax + DIST_MAX - 1) / DIST_MAX;
            lut[i] = 8'(pmax + pstart - c);
        end
        return lut;
    endfunction

    // truncated angle for each raw 8-bit two's complement wheel code
    function automatic angle_lut_t build_angle_lut();
        angle_lut_t lut;
        int         w;
        for (int i = 0; i < 256; i++) begin
            w = (i >= 128) ? i - 256 : i;
            lut[i] = 16'((w * ANGLE_NUM) / ANGLE_DEN);
        end
        return lut;
    endfunction

    localparam radar_lut_t RADAR_LUT_REV = build_radar_lut(PMAX_REV, PSTART_REV);
    localparam radar_lut_t RADAR_LUT_FWD = build_radar_lut(PMAX_FWD, PSTART_FWD);
    localparam angle_lut_t ANGLE_LUT     = build_angle_lut();

endpackage

FILE: sv/vsfe_frame_build.sv
// Combinational frame builder: turns one request into a complete framed report.
// Depends on vsfe_pkg for item and frame types, codes and lookup tables.
module vsfe_frame_build (
    input  vsfe_pkg::item_t  item,
    input  logic             park_latched,
    output vsfe_pkg::frame_t frame
);

    logic                                 on;
    logic [vsfe_pkg::PAY_MAX-1:0][7:0]    pay;
    logic [7:0]                           ftype;
    logic [4:0]                           n;
    logic [15:0]                          ang;
    logic [5:0][7:0]                      pair_sum;
    logic [2:0][7:0]                      quad_sum;
    logic [7:0]                           csum;
    logic                                 f_emit;
    logic                                 f_park_upd;
    logic                                 f_park_val;
    logic [vsfe_pkg::CNT_W-1:0]           f_len;
    logic [vsfe_pkg::FRAME_MAX-1:0][7:0]  f_bytes;

    assign on  = (item.radar_state == vsfe_pkg::RADAR_ON);
    assign ang = vsfe_pkg::ANGLE_LUT[$unsigned(item.wheel_percent)];

    always_comb begin
        pay        = '0;
        ftype      = 8'h00;
        n          = 5'd0;
        f_emit     = 1'b0;
        f_park_upd = 1'b0;
        f_park_val = on;
        case (item.func)
            vsfe_pkg::FUNC_WHEEL: begin
                f_emit     = item.wheel_valid && ((park_latched != on) || park_latched);
                f_park_upd = f_emit;
                ftype      = vsfe_pkg::TYPE_WHEEL;
                n          = vsfe_pkg::LEN_WHEEL;
                pay[0]     = on ? vsfe_pkg::PARK_FLAG0 : 8'h00;
                pay[4]     = on ? vsfe_pkg::PARK_FLAG4 : 8'h00;
                pay[6]     = ang[15:8];
                pay[7]     = ang[7:0];
            end
            vsfe_pkg::FUNC_DOOR: begin
                f_emit = 1'b1;
                ftype  = vsfe_pkg::TYPE_DOOR;
                n      = vsfe_pkg::LEN_DOOR;
                pay[2] = {item.door_open_mask, 2'b00};
            end
            vsfe_pkg::FUNC_RADAR: begin
                f_emit = on;
                ftype  = vsfe_pkg::TYPE_RADAR;
                n      = vsfe_pkg::LEN_RADAR;
                for (int i = 0; i < vsfe_pkg::LANES; i++) begin
                    pay[i] = item.reverse_selected
                           ? vsfe_pkg::RADAR_LUT_REV[item.radar_distances[i*vsfe_pkg::LANE_W +:
                                                                           vsfe_pkg::LANE_W]]
                           : vsfe_pkg::RADAR_LUT_FWD[item.radar_distances[i*vsfe_pkg::LANE_W +:
                                                                           vsfe_pkg::LANE_W]];
                end
            end
            default: begin
                f_emit = 1'b0;
            end
        endcase
    end

    // checksum as a shallow adder tree; unused payload bytes are zero
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            pair_sum[i] = pay[2*i] + pay[2*i+1];
        end
        for (int i = 0; i < 3; i++) begin
            quad_sum[i] = pair_sum[2*i] + pair_sum[2*i+1];
        end
        csum = quad_sum[0] + quad_sum[1] + quad_sum[2] + {3'b000, n} + ftype - 8'd1;
    end

    always_comb begin
        f_len      = n + 5'(vsfe_pkg::FRAME_OVERHEAD);
        f_bytes    = '0;
        f_bytes[0] = vsfe_pkg::SYNC0;
        f_bytes[1] = vsfe_pkg::SYNC1;
        f_bytes[2] = {3'b000, n};
        f_bytes[3] = ftype;
        for (int k = 0; k < vsfe_pkg::PAY_MAX; k++) begin
            f_bytes[4+k] = (5'(k) == n) ? csum : pay[k];
        end
        f_bytes[vsfe_pkg::FRAME_MAX-1] = (n == vsfe_pkg::LEN_RADAR) ? csum : 8'h00;
    end

    assign frame = {f_emit, f_park_upd, f_park_val, f_len, f_bytes};

endmodule

FILE: sv/vehicle_status_frame_encoder_core.sv
// Top level of the vehicle status frame encoder: input register, frame buffer, output register.
// Depends on vsfe_pkg and vsfe_frame_build.
//
// Each accepted request yields one framed report on the master side, one byte per beat, with
// tlast on the checksum byte: 15 beats for steering, 12 for doors, 17 for parking radar, or
// nothing when the report is suppressed. A request is held in the input register, built into
// the frame buffer and shifted out through the output register. A new request is taken every
// cycle while the frame buffer is free; the next request is built while the current frame
// drains, so sustained throughput is set by the one-byte-per-cycle output serializer while the
// receiver is ready, and a request that sends nothing does not wait for the frame buffer.
module vehicle_status_frame_encoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] wheel_valid, [8:1] wheel_percent, [10:9] radar_state, [11] reverse_selected,
    // [17:12] door_open_mask, [73:18] radar_distances, [79:74] zero
    input  logic [79:0] s_tdata,
    // [1:0] func
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] frame_byte
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    logic                                  in_valid_reg;
    vsfe_pkg::item_t                       in_item_reg;
    logic                                  park_latched_reg;

    logic                                  frm_valid_reg;
    logic [vsfe_pkg::CNT_W-1:0]            frm_cnt_reg;
    logic [vsfe_pkg::FRAME_MAX-1:0][7:0]   frm_bytes_reg;

    logic                                  m_tvalid_reg;
    logic [7:0]                            m_tdata_reg;
    logic                                  m_tlast_reg;

    vsfe_pkg::frame_t                      bld;
    logic                                  out_load;
    logic                                  frm_pop;
    logic                                  frm_free;
    logic                                  advance;
    logic                                  frm_load;
    logic                                  s_accept;

    vsfe_frame_build u_build (
        .item         (in_item_reg),
        .park_latched (park_latched_reg),
        .frame        (bld)
    );

    assign out_load = !m_tvalid_reg || m_tready;
    assign frm_pop  = frm_valid_reg && out_load;
    assign frm_free = !frm_valid_reg || (frm_pop && (frm_cnt_reg == vsfe_pkg::CNT_W'(1)));
    assign advance  = in_valid_reg && (frm_free || !bld.emit);
    assign frm_load = advance && bld.emit;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            park_latched_reg <= 1'b0;
            frm_valid_reg    <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance && bld.park_upd) begin
                park_latched_reg <= bld.park_val;
            end
            if (frm_load) begin
                frm_valid_reg <= 1'b1;
            end else if (frm_pop && (frm_cnt_reg == vsfe_pkg::CNT_W'(1))) begin
                frm_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_tvalid_reg <= frm_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.func             <= s_tuser;
            in_item_reg.wheel_valid      <= s_tdata[0];
            in_item_reg.wheel_percent    <= s_tdata[8:1];
            in_item_reg.radar_state      <= s_tdata[10:9];
            in_item_reg.reverse_selected <= s_tdata[11];
            in_item_reg.door_open_mask   <= s_tdata[17:12];
            in_item_reg.radar_distances  <= s_tdata[73:18];
        end
        if (frm_load) begin
            frm_bytes_reg <= bld.bytes;
            frm_cnt_reg   <= bld.len;
        end else if (frm_pop) begin
            frm_bytes_reg <= {8'h00, frm_bytes_reg[vsfe_pkg::FRAME_MAX-1:1]};
            frm_cnt_reg   <= frm_cnt_reg - vsfe_pkg::CNT_W'(1);
        end
        if (frm_pop) begin
            m_tdata_reg <= frm_bytes_reg[0];
            m_tlast_reg <= (frm_cnt_reg == vsfe_pkg::CNT_W'(1));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_frm_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        frm_valid_reg |-> (frm_cnt_reg != '0) &&
                          (frm_cnt_reg <= vsfe_pkg::CNT_W'(vsfe_pkg::FRAME_MAX)))
        else $error("frame buffer count out of range");

    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        frm_load |=> (frm_bytes_reg[0] == vsfe_pkg::SYNC0) &&
                     (frm_cnt_reg >= vsfe_pkg::CNT_W'(vsfe_pkg::LEN_DOOR +
                                                      vsfe_pkg::FRAME_OVERHEAD)))
        else $error("frame loaded without sync byte or with short length");

    a_last_on_final: assert property (@(posedge aclk) disable iff (!aresetn)
        frm_pop |=> m_tvalid && (m_tlast == ($past(frm_cnt_reg) == vsfe_pkg::CNT_W'(1))))
        else $error("tlast not aligned with final frame byte");

endmodule

FILE: tb/vsfe_frame_checker.sv
`timescale 1ns / 1ps
// Checker for vehicle_status_frame_encoder_core: predicts each framed report from the
// accepted requests and compares every master-side beat. Depends on vsfe_pkg.
module vsfe_frame_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    output int          mismatches,
    output int          beats_due,
    output int          requests_taken,
    output int          frames_done,
    output int          beats_checked
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_beat_t;

    frame_beat_t frame_bytes_due[$];
    logic        park_sent;
    int          err_cnt;
    int          req_cnt;
    int          frame_cnt;
    int          beat_cnt;

    // appends the frame a request causes, if any, and updates the park latch
    function automatic void encode_report(input logic [1:0] func, input logic [79:0] req);
        logic              wheel_ok;
        logic signed [7:0] wheel;
        logic [1:0]        radar;
        logic              rev;
        logic [5:0]        doors;
        logic [55:0]       dists;
        logic [7:0]        pay [vsfe_pkg::PAY_MAX];
        logic [7:0]        kind;
        logic [7:0]        sum;
        logic              park_on;
        logic [15:0]       angle;
        int                n;
        int                pmax;
        int                pstart;
        int                lane;
        int                c;
        wheel_ok = req[0];
        wheel    = req[8:1];
        radar    = req[10:9];
        rev      = req[11];
        doors    = req[17:12];
        dists    = req[73:18];
        foreach (pay[i]) pay[i] = 8'h00;
        n    = 0;
        kind = 8'h00;
        case (func)
            vsfe_pkg::FUNC_WHEEL: begin
                park_on = (radar == vsfe_pkg::RADAR_ON);
                if (wheel_ok && (park_on != park_sent || park_sent)) begin
                    park_sent = park_on;
                    angle  = 16'((int'(wheel) * vsfe_pkg::ANGLE_NUM) / vsfe_pkg::ANGLE_DEN);
                    pay[0] = park_on ? vsfe_pkg::PARK_FLAG0 : 8'h00;
                    pay[4] = park_on ? vsfe_pkg::PARK_FLAG4 : 8'h00;
                    pay[6] = angle[15:8];
                    pay[7] = angle[7:0];
                    n      = int'(vsfe_pkg::LEN_WHEEL);
                    kind   = vsfe_pkg::TYPE_WHEEL;
                end
            end
            vsfe_pkg::FUNC_DOOR: begin
                pay[2] = {doors, 2'b00};
                n      = int'(vsfe_pkg::LEN_DOOR);
                kind   = vsfe_pkg::TYPE_DOOR;
            end
            vsfe_pkg::FUNC_RADAR: begin
                if (radar == vsfe_pkg::RADAR_ON) begin
                    pmax   = rev ? vsfe_pkg::PMAX_REV : vsfe_pkg::PMAX_FWD;
                    pstart = rev ? vsfe_pkg::PSTART_REV : vsfe_pkg::PSTART_FWD;
                    for (int i = 0; i < vsfe_pkg::LANES; i++) begin
                        lane = int'(dists[vsfe_pkg::LANE_W*i +: vsfe_pkg::LANE_W]);
                        if (lane > vsfe_pkg::DIST_MAX) lane = vsfe_pkg::DIST_MAX;
                        c = (lane * pmax + vsfe_pkg::DIST_MAX - 1) / vsfe_pkg::DIST_MAX;
                        pay[i] = 8'(pmax + pstart - c);
                    end
                    n    = int'(vsfe_pkg::LEN_RADAR);
                    kind = vsfe_pkg::TYPE_RADAR;
                end
            end
            default: ;
        endcase
        if (n != 0) begin
            frame_bytes_due.push_back('{vsfe_pkg::SYNC0, 1'b0});
            frame_bytes_due.push_back('{vsfe_pkg::SYNC1, 1'b0});
            frame_bytes_due.push_back('{8'(n), 1'b0});
            frame_bytes_due.push_back('{kind, 1'b0});
            sum = 8'(n) + kind;
            for (int i = 0; i < n; i++) begin
                frame_bytes_due.push_back('{pay[i], 1'b0});
                sum = sum + pay[i];
            end
            frame_bytes_due.push_back('{sum - 8'd1, 1'b1});
        end
    endfunction

    always @(posedge aclk) begin
        frame_beat_t want;
        if (!aresetn) begin
            park_sent = 1'b0;
            frame_bytes_due.delete();
            err_cnt   = 0;
            req_cnt   = 0;
            frame_cnt = 0;
            beat_cnt  = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                req_cnt++;
                encode_report(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                beat_cnt++;
                if (m_tlast) frame_cnt++;
                if (frame_bytes_due.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: unexpected beat: byte %02h last %0b",
                                 $time, m_tdata, m_tlast);
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (m_tdata !== want.data || m_tlast !== want.last) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("%0t: beat %0d: expected %02h last %0b, got %02h last %0b",
                                     $time, beat_cnt, want.data, want.last, m_tdata, m_tlast);
                    end
                end
            end
        end
        mismatches     <= err_cnt;
        beats_due      <= frame_bytes_due.size();
        requests_taken <= req_cnt;
        frames_done    <= frame_cnt;
        beats_checked  <= beat_cnt;
    end

endmodule

FILE: tb/vehicle_status_frame_encoder_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for vehicle_status_frame_encoder_core: clock, reset, request stimulus,
// receiver back-pressure and verdict. Depends on vsfe_pkg, vsfe_frame_checker and the core.
module vehicle_status_frame_encoder_core_tb;

    localparam int         CLK_PERIOD     = 4;
    localparam int         HOLD_CYCLES    = 200;
    localparam int         TAIL_CYCLES    = 20;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam logic [1:0] FUNC_UNUSED    = 2'd3;
    localparam logic [1:0] RADAR_UNDEF    = 2'd0;
    localparam logic [1:0] RADAR_OFF      = 2'd1;
    localparam logic [1:0] RADAR_BAD      = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    int mismatches;
    int beats_due;
    int requests_taken;
    int frames_done;
    int beats_checked;

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_requests;
    int holds_served;
    int hold_left;
    int quiet_cycles;
    int directed_cnt;

    vehicle_status_frame_encoder_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    vsfe_frame_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatches     (mismatches),
        .beats_due      (beats_due),
        .requests_taken (requests_taken),
        .frames_done    (frames_done),
        .beats_checked  (beats_checked)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // receiver: random stalls, plus long hold-offs on request
    initial begin
        m_tready     = 1'b0;
        holds_served = 0;
        hold_left    = 0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_served) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d beats still due",
                     WATCHDOG_LIMIT, beats_due);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [79:0] pack_request(input logic wheel_ok, input logic [7:0] wheel,
                                                 input logic [1:0] radar, input logic rev,
                                                 input logic [5:0] doors,
                                                 input logic [55:0] dists);
        return {6'b0, dists, doors, rev, radar, wheel, wheel_ok};
    endfunction

    function automatic logic [79:0] random_request();
        logic [7:0]  wheel;
        logic [1:0]  radar;
        logic [55:0] dists;
        if ($urandom_range(9) == 0)
            wheel = 8'($urandom_range(255));
        else
            wheel = 8'($urandom_range(200) - 100);
        radar = ($urandom_range(9) < 6) ? vsfe_pkg::RADAR_ON : 2'($urandom_range(3));
        if ($urandom_range(7) == 0) begin
            dists = 56'({$urandom, $urandom});
        end else begin
            for (int i = 0; i < vsfe_pkg::LANES; i++)
                dists[vsfe_pkg::LANE_W*i +: vsfe_pkg::LANE_W] = ($urandom_range(9) == 0) ?
                    7'($urandom_range(127, 100)) : 7'($urandom_range(99));
        end
        return pack_request($urandom_range(99) < 85, wheel, radar, 1'($urandom_range(1)),
                            6'($urandom_range(63)), dists);
    endfunction

    function automatic logic [1:0] random_func();
        int r;
        r = $urandom_range(99);
        if (r < 35) return vsfe_pkg::FUNC_WHEEL;
        if (r < 55) return vsfe_pkg::FUNC_DOOR;
        if (r < 92) return vsfe_pkg::FUNC_RADAR;
        return FUNC_UNUSED;
    endfunction

    // entered and left in the time step of a rising edge
    task automatic send_request(input logic [1:0] func, input logic [79:0] req);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        s_tuser  <= func;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_request(random_func(), random_request());
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (beats_due != 0);
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = vsfe_pkg::FUNC_WHEEL;
        tx_idle_pct   = 16;
        rx_idle_pct   = 78;
        hold_requests = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // steering and park latch
        send_request(vsfe_pkg::FUNC_WHEEL, pack_request(1, 8'd40, RADAR_OFF, 0, 0, '0));
        send_request(vsfe_pkg::FUNC_WHEEL,
                     pack_request(0, 8'd40, vsfe_pkg::RADAR_ON, 0, 0, '0));
        send_request(vsfe_pkg::FUNC_WHEEL,
                     pack_request(1, 8'd100, vsfe_pkg::RADAR_ON, 0, 0, '0));
        send_request(vsfe_pkg::FUNC_WHEEL,
                     pack_request(1, -8'sd100, vsfe_pkg::RADAR_ON, 1, 6'h3f, '1));
        send_request(vsfe_pkg::FUNC_WHEEL,
                     pack_request(1, 8'h7f, vsfe_pkg::RADAR_ON, 0, 0, '0));
        send_request(vsfe_pkg::FUNC_WHEEL,
                     pack_request(1, 8'h80, vsfe_pkg::RADAR_ON, 0, 0, '0));
        send_request(vsfe_pkg::FUNC_WHEEL,
                     pack_request(1, 8'hff, vsfe_pkg::RADAR_ON, 0, 0, '0));
        send_request(vsfe_pkg::FUNC_WHEEL, pack_request(1, 8'd0, RADAR_BAD, 0, 0, '0));
        send_request(vsfe_pkg::FUNC_WHEEL, pack_request(1, 8'd7, RADAR_UNDEF, 0, 0, '0));
        // doors
        send_request(vsfe_pkg::FUNC_DOOR, pack_request(0, 8'd0, RADAR_UNDEF, 0, 6'h00, '0));
        send_request(vsfe_pkg::FUNC_DOOR,
                     pack_request(1, 8'hff, vsfe_pkg::RADAR_ON, 1, 6'h3f, '1));
        send_request(vsfe_pkg::FUNC_DOOR, pack_request(0, 8'd0, RADAR_OFF, 0, 6'h15, '0));
        send_request(vsfe_pkg::FUNC_DOOR, pack_request(0, 8'd0, RADAR_OFF, 0, 6'h2a, '0));
        // radar: range ends, saturation, both gear positions
        send_request(vsfe_pkg::FUNC_RADAR,
                     pack_request(0, 8'd0, vsfe_pkg::RADAR_ON, 0, 0, {8{7'd0}}));
        send_request(vsfe_pkg::FUNC_RADAR,
                     pack_request(0, 8'd0, vsfe_pkg::RADAR_ON, 0, 0, {8{7'd99}}));
        send_request(vsfe_pkg::FUNC_RADAR,
                     pack_request(0, 8'd0, vsfe_pkg::RADAR_ON, 1, 0, {8{7'd0}}));
        send_request(vsfe_pkg::FUNC_RADAR,
                     pack_request(0, 8'd0, vsfe_pkg::RADAR_ON, 1, 0, {8{7'd99}}));
        send_request(vsfe_pkg::FUNC_RADAR,
                     pack_request(0, 8'd0, vsfe_pkg::RADAR_ON, 0, 0, {8{7'd127}}));
        send_request(vsfe_pkg::FUNC_RADAR, pack_request(0, 8'd0, vsfe_pkg::RADAR_ON, 1, 0,
                     {7'd100, 7'd98, 7'd66, 7'd50, 7'd33, 7'd2, 7'd1, 7'd0}));
        send_request(vsfe_pkg::FUNC_RADAR,
                     pack_request(1, 8'hff, vsfe_pkg::RADAR_ON, 1, 6'h3f, '1));
        send_request(vsfe_pkg::FUNC_RADAR, pack_request(0, 8'd0, RADAR_OFF, 0, 0, {8{7'd10}}));
        send_request(vsfe_pkg::FUNC_RADAR, pack_request(0, 8'd0, RADAR_BAD, 1, 0, {8{7'd10}}));
        send_request(vsfe_pkg::FUNC_RADAR,
                     pack_request(0, 8'd0, RADAR_UNDEF, 0, 0, {8{7'd10}}));
        // unused function code
        send_request(FUNC_UNUSED, pack_request(1, 8'hff, vsfe_pkg::RADAR_ON, 1, 6'h3f, '1));
        send_request(FUNC_UNUSED, '0);
        directed_cnt = 25;

        send_random(30);

        // long receiver hold-off while requests keep coming, then a full drain
        tx_idle_pct = 0;
        hold_requests++;
        send_random(12);
        wait_drained();

        tx_idle_pct = 78;
        rx_idle_pct = 16;
        send_random(27);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(27);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d requests (%0d directed), %0d frames, %0d beats checked",
                 requests_taken, directed_cnt, frames_done, beats_checked);
        $display("idle mixes 16/78, 78/16 and none, one %0d-cycle receiver hold-off",
                 HOLD_CYCLES);
        if (mismatches == 0 && beats_due == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
sv/vsfe_pkg.sv
sv/vsfe_frame_build.sv
sv/vehicle_status_frame_encoder_core.sv
tb/vsfe_frame_checker.sv
tb/vehicle_status_frame_encoder_core_tb.sv
